// ----- rtl/core/dam_pkg.sv -----
// ----------------------------------------------------------------------------
// DRAM address mapper package
// Register indexes, field orders, the configuration bundle and a mask helper
// shared by the mapper's modules.
// ----------------------------------------------------------------------------
package dam_pkg;

  // Configuration port widths
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 8;

  // Bit position inside the address; wide enough for every sum of widths
  localparam int unsigned PosW = 7;

  // Width of the mask helper result
  localparam int unsigned MaskW = 32;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SCHEME      = 4'd0,
    REG_RANK_BITS   = 4'd1,
    REG_BANK_BITS   = 4'd2,
    REG_ROW_BITS    = 4'd3,
    REG_COL_BITS    = 4'd4,
    REG_BUS_OFFSET  = 4'd5,
    REG_CHAN_BITS   = 4'd6,
    REG_LINE_OFFSET = 4'd7
  } cfg_idx_e;

  // Field orders, most significant field first
  typedef enum logic [2:0] {
    MAP_BK_COLHI_ROW_RK  = 3'd0,
    MAP_COLHI_ROW_RK_BK  = 3'd1,
    MAP_RK_BK_ROW_COLHI  = 3'd2,
    MAP_ROW_CH_BK_RK_COL = 3'd3,
    MAP_ROW_BK_RK_CH_COL = 3'd4,
    MAP_ROW_BK_RK_COLHI  = 3'd5,
    MAP_ROW_COLHI_BK_RK  = 3'd6,
    MAP_CH_ROW_BK_RK_COL = 3'd7
  } scheme_e;

  // Configuration bundle handed from the register file to the slicer
  typedef struct packed {
    scheme_e    scheme;
    logic [2:0] rank_bits;
    logic [2:0] bank_bits;
    logic [4:0] row_bits;
    logic [3:0] col_bits;
    logic [2:0] bus_offset_bits;
    logic [2:0] channel_bits;
    logic [3:0] line_offset_bits;
  } cfg_t;

  // Reset values
  localparam scheme_e    RstScheme     = MAP_BK_COLHI_ROW_RK;
  localparam logic [2:0] RstRankBits   = 3'd1;
  localparam logic [2:0] RstBankBits   = 3'd3;
  localparam logic [4:0] RstRowBits    = 5'd15;
  localparam logic [3:0] RstColBits    = 4'd10;
  localparam logic [2:0] RstBusOffset  = 3'd3;
  localparam logic [2:0] RstChanBits   = 3'd0;
  localparam logic [3:0] RstLineOffset = 4'd6;

  // Ones in every bit below the given width
  function automatic logic [MaskW-1:0] field_mask(input logic [4:0] width);
    logic [MaskW-1:0] m;
    for (int unsigned i = 0; i < MaskW; i++) begin
      m[i] = (i < 32'(width));
    end
    return m;
  endfunction

endpackage

// ----- rtl/core/dam_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// DRAM address mapper configuration registers
// Holds the field order and field widths; each write keeps only the
// register's own width, and writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module dam_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [dam_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  logic [dam_pkg::CfgDataW-1:0] wr_data_i,
  output dam_pkg::cfg_t                cfg_o
);

  dam_pkg::cfg_t cfg_d, cfg_q;

  // Decode the write word into the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (dam_pkg::cfg_idx_e'(wr_idx_i))
        dam_pkg::REG_SCHEME:      cfg_d.scheme           = dam_pkg::scheme_e'(wr_data_i[2:0]);
        dam_pkg::REG_RANK_BITS:   cfg_d.rank_bits        = wr_data_i[2:0];
        dam_pkg::REG_BANK_BITS:   cfg_d.bank_bits        = wr_data_i[2:0];
        dam_pkg::REG_ROW_BITS:    cfg_d.row_bits         = wr_data_i[4:0];
        dam_pkg::REG_COL_BITS:    cfg_d.col_bits         = wr_data_i[3:0];
        dam_pkg::REG_BUS_OFFSET:  cfg_d.bus_offset_bits  = wr_data_i[2:0];
        dam_pkg::REG_CHAN_BITS:   cfg_d.channel_bits     = wr_data_i[2:0];
        dam_pkg::REG_LINE_OFFSET: cfg_d.line_offset_bits = wr_data_i[3:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  // Hold the registers, load reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scheme           <= dam_pkg::RstScheme;
      cfg_q.rank_bits        <= dam_pkg::RstRankBits;
      cfg_q.bank_bits        <= dam_pkg::RstBankBits;
      cfg_q.row_bits         <= dam_pkg::RstRowBits;
      cfg_q.col_bits         <= dam_pkg::RstColBits;
      cfg_q.bus_offset_bits  <= dam_pkg::RstBusOffset;
      cfg_q.channel_bits     <= dam_pkg::RstChanBits;
      cfg_q.line_offset_bits <= dam_pkg::RstLineOffset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/dam_field_slicer.sv -----
// ----------------------------------------------------------------------------
// DRAM address mapper field slicer
// Works out where each field starts for the selected order and cuts rank,
// bank, row and column out of the registered address.
// ----------------------------------------------------------------------------
module dam_field_slicer #(
  parameter int unsigned ADDRESS_BITS    = 64,
  parameter int unsigned RANK_FIELD_BITS = 4,
  parameter int unsigned BANK_FIELD_BITS = 4,
  parameter int unsigned ROW_FIELD_BITS  = 20,
  parameter int unsigned COL_FIELD_BITS  = 14
) (
  input  logic [ADDRESS_BITS-1:0]    addr_i,
  input  dam_pkg::cfg_t              cfg_i,
  output logic [RANK_FIELD_BITS-1:0] rank_o,
  output logic [BANK_FIELD_BITS-1:0] bank_o,
  output logic [ROW_FIELD_BITS-1:0]  row_o,
  output logic [COL_FIELD_BITS-1:0]  col_o
);

  localparam int unsigned PosW = dam_pkg::PosW;

  logic                     aligned;
  logic [3:0]               lo_w;
  logic [3:0]               hi_w;
  logic [3:0]               col_w;
  logic [PosW-1:0]          base;
  logic [PosW-1:0]          p_rk, p_bk, p_rw, p_cl;
  logic [PosW-1:0]          w_rk, w_bk, w_rw, w_cl, w_ch;
  logic [ADDRESS_BITS-1:0]  rk_sh, bk_sh, rw_sh, cl_sh;
  logic [dam_pkg::MaskW-1:0] rk_m, bk_m, rw_m, cl_m;
  logic [COL_FIELD_BITS-1:0] col_raw;

  // Derive the column split and the start of the first field
  always_comb begin
    aligned = !(cfg_i.scheme == dam_pkg::MAP_ROW_CH_BK_RK_COL ||
                cfg_i.scheme == dam_pkg::MAP_ROW_BK_RK_CH_COL ||
                cfg_i.scheme == dam_pkg::MAP_CH_ROW_BK_RK_COL);
    lo_w = (cfg_i.line_offset_bits > {1'b0, cfg_i.bus_offset_bits}) ?
           cfg_i.line_offset_bits - {1'b0, cfg_i.bus_offset_bits} : 4'd0;
    hi_w = (cfg_i.col_bits > lo_w) ? cfg_i.col_bits - lo_w : 4'd0;
    col_w = aligned ? hi_w : cfg_i.col_bits;
    base = aligned ? PosW'(cfg_i.channel_bits) + PosW'(cfg_i.line_offset_bits)
                   : PosW'(cfg_i.bus_offset_bits);
    w_rk = PosW'(cfg_i.rank_bits);
    w_bk = PosW'(cfg_i.bank_bits);
    w_rw = PosW'(cfg_i.row_bits);
    w_cl = PosW'(col_w);
    w_ch = PosW'(cfg_i.channel_bits);
  end

  // Stack the fields upward from the base in the selected order
  always_comb begin
    p_rk = base;
    p_bk = base;
    p_rw = base;
    p_cl = base;
    unique case (cfg_i.scheme)
      dam_pkg::MAP_BK_COLHI_ROW_RK: begin
        p_rk = base;
        p_rw = p_rk + w_rk;
        p_cl = p_rw + w_rw;
        p_bk = p_cl + w_cl;
      end
      dam_pkg::MAP_COLHI_ROW_RK_BK: begin
        p_bk = base;
        p_rk = p_bk + w_bk;
        p_rw = p_rk + w_rk;
        p_cl = p_rw + w_rw;
      end
      dam_pkg::MAP_RK_BK_ROW_COLHI: begin
        p_cl = base;
        p_rw = p_cl + w_cl;
        p_bk = p_rw + w_rw;
        p_rk = p_bk + w_bk;
      end
      dam_pkg::MAP_ROW_BK_RK_COLHI: begin
        p_cl = base;
        p_rk = p_cl + w_cl;
        p_bk = p_rk + w_rk;
        p_rw = p_bk + w_bk;
      end
      dam_pkg::MAP_ROW_COLHI_BK_RK: begin
        p_rk = base;
        p_bk = p_rk + w_rk;
        p_cl = p_bk + w_bk;
        p_rw = p_cl + w_cl;
      end
      dam_pkg::MAP_ROW_CH_BK_RK_COL: begin
        p_cl = base;
        p_rk = p_cl + w_cl;
        p_bk = p_rk + w_rk;
        p_rw = p_bk + w_bk + w_ch;
      end
      dam_pkg::MAP_ROW_BK_RK_CH_COL: begin
        p_cl = base;
        p_rk = p_cl + w_cl + w_ch;
        p_bk = p_rk + w_rk;
        p_rw = p_bk + w_bk;
      end
      dam_pkg::MAP_CH_ROW_BK_RK_COL: begin
        p_cl = base;
        p_rk = p_cl + w_cl;
        p_bk = p_rk + w_rk;
        p_rw = p_bk + w_bk;
      end
      default: begin
        p_rk = base;
        p_bk = base;
        p_rw = base;
        p_cl = base;
      end
    endcase
  end

  // Align each field to bit zero; bits past the address read as zero
  assign rk_sh = addr_i >> p_rk;
  assign bk_sh = addr_i >> p_bk;
  assign rw_sh = addr_i >> p_rw;
  assign cl_sh = addr_i >> p_cl;

  assign rk_m = dam_pkg::field_mask({2'b00, cfg_i.rank_bits});
  assign bk_m = dam_pkg::field_mask({2'b00, cfg_i.bank_bits});
  assign rw_m = dam_pkg::field_mask(cfg_i.row_bits);
  assign cl_m = dam_pkg::field_mask({1'b0, col_w});

  // Trim to the configured widths
  assign rank_o  = rk_sh[RANK_FIELD_BITS-1:0] & rk_m[RANK_FIELD_BITS-1:0];
  assign bank_o  = bk_sh[BANK_FIELD_BITS-1:0] & bk_m[BANK_FIELD_BITS-1:0];
  assign row_o   = rw_sh[ROW_FIELD_BITS-1:0] & rw_m[ROW_FIELD_BITS-1:0];
  assign col_raw = cl_sh[COL_FIELD_BITS-1:0] & cl_m[COL_FIELD_BITS-1:0];

  // Shift the column high part back over the implied low bits
  assign col_o = aligned ? (col_raw << lo_w) : col_raw;

endmodule

// ----- rtl/core/dram_address_mapper_core.sv -----
// ----------------------------------------------------------------------------
// DRAM address mapper core
// The incoming word is captured into addr_q, cut up by the slicer, and the
// result is loaded into the output registers with done_o raised alongside.
// Throughput: one word per cycle; busy never rises and the result side
// cannot stall. Reset clears the strobes and loads the register defaults.
// ----------------------------------------------------------------------------
module dram_address_mapper_core #(
  parameter int unsigned ADDRESS_BITS    = 64,
  parameter int unsigned RANK_FIELD_BITS = 4,
  parameter int unsigned BANK_FIELD_BITS = 4,
  parameter int unsigned ROW_FIELD_BITS  = 20,
  parameter int unsigned COL_FIELD_BITS  = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [63:0]                  phys_addr_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dam_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dam_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         done_o,
  output logic [RANK_FIELD_BITS-1:0]   rank_idx_o,
  output logic [BANK_FIELD_BITS-1:0]   bank_idx_o,
  output logic [ROW_FIELD_BITS-1:0]    row_idx_o,
  output logic [COL_FIELD_BITS-1:0]    col_idx_o
);

  dam_pkg::cfg_t               cfg;
  logic                        accept;
  logic                        vld_q;
  logic                        done_q;
  logic [ADDRESS_BITS-1:0]     addr_q;
  logic [RANK_FIELD_BITS-1:0]  rank_d, rank_q;
  logic [BANK_FIELD_BITS-1:0]  bank_d, bank_q;
  logic [ROW_FIELD_BITS-1:0]   row_d, row_q;
  logic [COL_FIELD_BITS-1:0]   col_d, col_q;

  // Always ready on both ports
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  dam_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // Strobes through the two register stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= accept;
      done_q <= vld_q;
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= phys_addr_i[ADDRESS_BITS-1:0];
    end
  end

  dam_field_slicer #(
    .ADDRESS_BITS    (ADDRESS_BITS),
    .RANK_FIELD_BITS (RANK_FIELD_BITS),
    .BANK_FIELD_BITS (BANK_FIELD_BITS),
    .ROW_FIELD_BITS  (ROW_FIELD_BITS),
    .COL_FIELD_BITS  (COL_FIELD_BITS)
  ) u_field_slicer (
    .addr_i (addr_q),
    .cfg_i  (cfg),
    .rank_o (rank_d),
    .bank_o (bank_d),
    .row_o  (row_d),
    .col_o  (col_d)
  );

  // Register the result word
  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      rank_q <= rank_d;
      bank_q <= bank_d;
      row_q  <= row_d;
      col_q  <= col_d;
    end
  end

  assign done_o     = done_q;
  assign rank_idx_o = rank_q;
  assign bank_idx_o = bank_q;
  assign row_idx_o  = row_q;
  assign col_idx_o  = col_q;

endmodule
